// File: rtl/core/nsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsl_pkg
// Shared types and constants of the nearest-seed labeler.
// ----------------------------------------------------------------------------
package nsl_pkg;

   localparam int COORD_BITS  = 10;
   localparam int LABEL_BITS  = 8;
   localparam int INDEX_BITS  = 8;
   localparam int NSEED_BITS  = 9;
   localparam int EXTENT_BITS = 11;
   localparam int CSR_BITS    = 11;
   localparam int DIST_BITS   = 27;

   // running best starts at 10000 squared
   localparam logic [DIST_BITS-1:0] SEARCH_LIMIT = 27'd100000000;

   localparam logic [NSEED_BITS-1:0]  RESET_NUM_SEEDS  = 9'd150;
   localparam logic [EXTENT_BITS-1:0] RESET_MAP_EXTENT = 11'd1000;

   localparam logic CSR_NUM_SEEDS  = 1'b0;
   localparam logic CSR_MAP_EXTENT = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD     = 2'd0,
      KIND_CLASSIFY = 2'd1,
      KIND_RELAX    = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEARCH,
      ST_BOX_RD,
      ST_BOX_WR,
      ST_RELAX_RD,
      ST_RELAX_WR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                  done;
      logic [LABEL_BITS-1:0] label;
   } srch_res_type;

endpackage
`default_nettype wire

// File: rtl/core/nsl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nsl_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/core/nsl_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsl_search
// Sweeps the seed RAM one entry a cycle and keeps the nearest seed.
// Stages: address issue, RAM read, abs diff and square, sum and compare.
// ----------------------------------------------------------------------------
module nsl_search #(
   parameter int MAX_SEEDS = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [nsl_pkg::NSEED_BITS-1:0]       num_seeds,
   input  wire logic [nsl_pkg::COORD_BITS-1:0]       px,
   input  wire logic [nsl_pkg::COORD_BITS-1:0]       py,
   output logic      [$clog2(MAX_SEEDS)-1:0]         rd_addr,
   input  wire logic [2*nsl_pkg::COORD_BITS-1:0]     rd_data,
   output nsl_pkg::srch_res_type                     res
);

   localparam int IDX_W = $clog2(MAX_SEEDS);
   localparam int CNT_W = $clog2(MAX_SEEDS + 1);
   localparam int CB    = nsl_pkg::COORD_BITS;
   localparam int SQ_W  = 2 * CB;
   localparam int DW    = nsl_pkg::DIST_BITS;
   localparam int LBL_W = nsl_pkg::LABEL_BITS;
   localparam int NSEED_BITS_EXT = nsl_pkg::NSEED_BITS + 1;

   logic             run_ff,    run_in;
   logic             issue_ff,  issue_in;
   logic [CNT_W-1:0] addr_ff,   addr_in;
   logic [CNT_W-1:0] cnt_ff,    cnt_in;
   logic             s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0] s1_idx_ff, s1_idx_in;
   logic             s2_vld_ff, s2_vld_in;
   logic [IDX_W-1:0] s2_idx_ff, s2_idx_in;
   logic [SQ_W-1:0]  sqx_ff,    sqx_in;
   logic [SQ_W-1:0]  sqy_ff,    sqy_in;
   logic [DW-1:0]    best_ff,   best_in;
   logic [IDX_W-1:0] win_ff,    win_in;
   logic             done_ff,   done_in;

   logic [CNT_W-1:0] clip_cnt;
   logic [CB-1:0]    sx, sy, dx, dy;
   logic [DW-1:0]    sq_dist;
   logic [CNT_W-1:0] addr_nxt;

   // seed count, capped at the table depth
   always_comb begin
      if ((NSEED_BITS_EXT'(num_seeds)) > (NSEED_BITS_EXT'(MAX_SEEDS))) begin
         clip_cnt = CNT_W'(MAX_SEEDS);
      end else begin
         clip_cnt = CNT_W'(num_seeds);
      end
   end

   assign sx       = rd_data[SQ_W-1:CB];
   assign sy       = rd_data[CB-1:0];
   assign dx       = (px >= sx) ? (px - sx) : (sx - px);
   assign dy       = (py >= sy) ? (py - sy) : (sy - py);
   assign sq_dist  = DW'({1'b0, sqx_ff} + {1'b0, sqy_ff});
   assign addr_nxt = addr_ff + CNT_W'(1);
   assign rd_addr  = addr_ff[IDX_W-1:0];

   always_comb begin
      run_in    = run_ff;
      issue_in  = issue_ff;
      addr_in   = addr_ff;
      cnt_in    = cnt_ff;
      best_in   = best_ff;
      win_in    = win_ff;
      s1_vld_in = issue_ff;
      s1_idx_in = addr_ff[IDX_W-1:0];
      s2_vld_in = s1_vld_ff;
      s2_idx_in = s1_idx_ff;
      sqx_in    = SQ_W'(dx) * SQ_W'(dx);
      sqy_in    = SQ_W'(dy) * SQ_W'(dy);
      done_in   = 1'b0;

      if (issue_ff) begin
         addr_in  = addr_nxt;
         issue_in = (addr_nxt != cnt_ff);
      end

      if (s2_vld_ff && (sq_dist < best_ff)) begin
         best_in = sq_dist;
         win_in  = s2_idx_ff;
      end

      if (run_ff && !issue_ff && !s1_vld_ff && !s2_vld_ff) begin
         done_in = 1'b1;
         run_in  = 1'b0;
      end

      if (start) begin
         run_in   = 1'b1;
         cnt_in   = clip_cnt;
         addr_in  = '0;
         issue_in = (clip_cnt != '0);
         best_in  = nsl_pkg::SEARCH_LIMIT;
         win_in   = '0;
         done_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         issue_ff  <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         run_ff    <= run_in;
         issue_ff  <= issue_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      cnt_ff    <= cnt_in;
      s1_idx_ff <= s1_idx_in;
      s2_idx_ff <= s2_idx_in;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      best_ff   <= best_in;
      win_ff    <= win_in;
   end

   assign res.done  = done_ff;
   assign res.label = LBL_W'(win_ff);

endmodule
`default_nettype wire

// File: rtl/core/nearest_seed_labeler_with_relaxation_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_seed_labeler_with_relaxation_unit
// Seed table and per-region bounding boxes in RAM; nearest-seed search,
// box widening and box-centre relaxation.
// ----------------------------------------------------------------------------
// Flow: load passes ST_LOAD; relax ST_RELAX_RD, ST_RELAX_WR; classify ST_SEARCH
//   (capped seed count), ST_BOX_RD, ST_BOX_WR; then ST_OUT loads the rsp regs.
// Throughput: one item at a time; classify is bound by the seed RAM read
//   port, one seed per cycle. A new item is taken while a result waits.
// Reset: synchronous; clears control, region flags and the registers
//   (num_seeds 150, map_extent 1000). Seed RAM holds nothing until loaded.
module nearest_seed_labeler_with_relaxation_unit #(
   parameter int MAX_SEEDS = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_kind,
   input  wire logic [nsl_pkg::INDEX_BITS-1:0]      req_seed_index,
   input  wire logic [nsl_pkg::COORD_BITS-1:0]      req_coord_x,
   input  wire logic [nsl_pkg::COORD_BITS-1:0]      req_coord_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [nsl_pkg::LABEL_BITS-1:0]      rsp_label,
   output logic      [nsl_pkg::COORD_BITS-1:0]      rsp_centre_x,
   output logic      [nsl_pkg::COORD_BITS-1:0]      rsp_centre_y,
   input  wire logic                                csr_we,
   input  wire logic                                csr_index,
   input  wire logic [nsl_pkg::CSR_BITS-1:0]        csr_wdata
);

   localparam int IDX_W = $clog2(MAX_SEEDS);
   localparam int CB    = nsl_pkg::COORD_BITS;
   localparam int LB    = nsl_pkg::LABEL_BITS;
   localparam int IB    = nsl_pkg::INDEX_BITS;
   localparam int SW    = 2 * CB;
   localparam int BW    = 4 * CB;

   nsl_pkg::state_type state_ff, state_in;

   logic [nsl_pkg::NSEED_BITS-1:0]  num_seeds_ff,  num_seeds_in;
   logic [nsl_pkg::EXTENT_BITS-1:0] map_extent_ff, map_extent_in;

   logic [IB-1:0]     idx_ff,    idx_in;
   logic [CB-1:0]     px_ff,     px_in;
   logic [CB-1:0]     py_ff,     py_in;
   logic [LB-1:0]     res_label_ff, res_label_in;
   logic [CB-1:0]     res_x_ff,  res_x_in;
   logic [CB-1:0]     res_y_ff,  res_y_in;
   logic              start_ff,  start_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [LB-1:0]     rsp_label_ff, rsp_label_in;
   logic [CB-1:0]     rsp_x_ff,     rsp_x_in;
   logic [CB-1:0]     rsp_y_ff,     rsp_y_in;

   logic [MAX_SEEDS-1:0] seen_ff, seen_in;

   logic                 accept;
   logic                 out_load;
   nsl_pkg::kind_type    req_kind_t;
   logic                 req_idx_ok;

   logic                 seed_we;
   logic [IDX_W-1:0]     seed_waddr;
   logic [SW-1:0]        seed_wdata;
   logic [IDX_W-1:0]     seed_raddr;
   logic [SW-1:0]        seed_rdata;

   logic                 box_we;
   logic [IDX_W-1:0]     box_waddr;
   logic [BW-1:0]        box_wdata;
   logic [IDX_W-1:0]     box_raddr;
   logic [BW-1:0]        box_rdata;

   logic                 seen_set;
   logic                 seen_clr;
   logic [IDX_W-1:0]     seen_addr;

   nsl_pkg::srch_res_type srch_res;

   logic [IDX_W-1:0]     lbl_addr;
   logic [IDX_W-1:0]     idx_addr;
   logic [CB-1:0]        bmin_x, bmax_x, bmin_y, bmax_y;
   logic [CB-1:0]        nmin_x, nmax_x, nmin_y, nmax_y;
   logic [CB:0]          sum_x, sum_y;
   logic [CB-1:0]        half_ext;

   assign req_kind_t = nsl_pkg::kind_type'(req_kind);
   assign req_idx_ok = ({1'b0, req_seed_index} < (IB + 1)'(MAX_SEEDS));
   assign req_stall  = (state_ff != nsl_pkg::ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_load   = (state_ff == nsl_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign lbl_addr = res_label_ff[IDX_W-1:0];
   assign idx_addr = idx_ff[IDX_W-1:0];

   assign {bmin_x, bmax_x, bmin_y, bmax_y} = box_rdata;
   assign nmin_x   = (px_ff < bmin_x) ? px_ff : bmin_x;
   assign nmax_x   = (px_ff > bmax_x) ? px_ff : bmax_x;
   assign nmin_y   = (py_ff < bmin_y) ? py_ff : bmin_y;
   assign nmax_y   = (py_ff > bmax_y) ? py_ff : bmax_y;
   assign sum_x    = {1'b0, bmin_x} + {1'b0, bmax_x};
   assign sum_y    = {1'b0, bmin_y} + {1'b0, bmax_y};
   assign half_ext = CB'(map_extent_ff >> 1);

   // ---------------------------------------------------------------- memories
   nsl_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_SEEDS)
   ) u_seed_ram (
      .clock (clock),
      .we    (seed_we),
      .waddr (seed_waddr),
      .wdata (seed_wdata),
      .raddr (seed_raddr),
      .rdata (seed_rdata)
   );

   nsl_ram #(
      .WIDTH (BW),
      .DEPTH (MAX_SEEDS)
   ) u_box_ram (
      .clock (clock),
      .we    (box_we),
      .waddr (box_waddr),
      .wdata (box_wdata),
      .raddr (box_raddr),
      .rdata (box_rdata)
   );

   nsl_search #(
      .MAX_SEEDS (MAX_SEEDS)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .num_seeds (num_seeds_ff),
      .px        (px_ff),
      .py        (py_ff),
      .rd_addr   (seed_raddr),
      .rd_data   (seed_rdata),
      .res       (srch_res)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nsl_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_kind_t)
                  nsl_pkg::KIND_LOAD: begin
                     state_in = req_idx_ok ? nsl_pkg::ST_LOAD : nsl_pkg::ST_OUT;
                  end
                  nsl_pkg::KIND_CLASSIFY: begin
                     state_in = nsl_pkg::ST_SEARCH;
                  end
                  nsl_pkg::KIND_RELAX: begin
                     state_in = req_idx_ok ? nsl_pkg::ST_RELAX_RD : nsl_pkg::ST_OUT;
                  end
                  default: begin
                     state_in = nsl_pkg::ST_OUT;
                  end
               endcase
            end
         end
         nsl_pkg::ST_LOAD:     state_in = nsl_pkg::ST_OUT;
         nsl_pkg::ST_SEARCH: begin
            if (srch_res.done) begin
               state_in = nsl_pkg::ST_BOX_RD;
            end
         end
         nsl_pkg::ST_BOX_RD:   state_in = nsl_pkg::ST_BOX_WR;
         nsl_pkg::ST_BOX_WR:   state_in = nsl_pkg::ST_OUT;
         nsl_pkg::ST_RELAX_RD: state_in = nsl_pkg::ST_RELAX_WR;
         nsl_pkg::ST_RELAX_WR: state_in = nsl_pkg::ST_OUT;
         nsl_pkg::ST_OUT: begin
            if (out_load) begin
               state_in = nsl_pkg::ST_IDLE;
            end
         end
         default:              state_in = nsl_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      seed_we    = 1'b0;
      seed_waddr = idx_addr;
      seed_wdata = {px_ff, py_ff};
      box_we     = 1'b0;
      box_waddr  = lbl_addr;
      box_wdata  = {nmin_x, nmax_x, nmin_y, nmax_y};
      box_raddr  = lbl_addr;
      seen_set   = 1'b0;
      seen_clr   = 1'b0;
      seen_addr  = lbl_addr;
      res_label_in = res_label_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      case (state_ff)
         nsl_pkg::ST_LOAD: begin
            seed_we = 1'b1;
         end
         nsl_pkg::ST_SEARCH: begin
            if (srch_res.done) begin
               res_label_in = srch_res.label;
            end
         end
         nsl_pkg::ST_BOX_WR: begin
            box_we   = 1'b1;
            seen_set = 1'b1;
            // first pixel of a region starts a fresh box
            if (!seen_ff[lbl_addr]) begin
               box_wdata = {px_ff, px_ff, py_ff, py_ff};
            end
         end
         nsl_pkg::ST_RELAX_RD: begin
            box_raddr = idx_addr;
         end
         nsl_pkg::ST_RELAX_WR: begin
            seen_clr  = 1'b1;
            seen_addr = idx_addr;
            seed_we   = 1'b1;
            if (seen_ff[idx_addr]) begin
               res_x_in = sum_x[CB:1];
               res_y_in = sum_y[CB:1];
            end else begin
               res_x_in = half_ext;
               res_y_in = half_ext;
            end
            seed_wdata = {res_x_in, res_y_in};
         end
         default: begin
         end
      endcase
      if (accept) begin
         res_label_in = '0;
         res_x_in     = '0;
         res_y_in     = '0;
      end
   end

   // ---------------------------------------------------------------- item regs
   always_comb begin
      idx_in    = idx_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      if (accept) begin
         idx_in    = req_seed_index;
         px_in     = req_coord_x;
         py_in     = req_coord_y;
      end
      start_in = accept && (req_kind_t == nsl_pkg::KIND_CLASSIFY);
   end

   always_comb begin
      seen_in = seen_ff;
      if (seen_set) begin
         seen_in[seen_addr] = 1'b1;
      end
      if (seen_clr) begin
         seen_in[seen_addr] = 1'b0;
      end
   end

   always_comb begin
      num_seeds_in  = num_seeds_ff;
      map_extent_in = map_extent_ff;
      if (csr_we) begin
         case (csr_index)
            nsl_pkg::CSR_NUM_SEEDS:  num_seeds_in  = csr_wdata[nsl_pkg::NSEED_BITS-1:0];
            nsl_pkg::CSR_MAP_EXTENT: map_extent_in = csr_wdata[nsl_pkg::EXTENT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_label_in = rsp_label_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_label_in = res_label_ff;
         rsp_x_in     = res_x_ff;
         rsp_y_in     = res_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nsl_pkg::ST_IDLE;
         num_seeds_ff  <= nsl_pkg::RESET_NUM_SEEDS;
         map_extent_ff <= nsl_pkg::RESET_MAP_EXTENT;
         seen_ff       <= '0;
         start_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_seeds_ff  <= num_seeds_in;
         map_extent_ff <= map_extent_in;
         seen_ff       <= seen_in;
         start_ff      <= start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      res_label_ff <= res_label_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      rsp_label_ff <= rsp_label_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_label    = rsp_label_ff;
   assign rsp_centre_x = rsp_x_ff;
   assign rsp_centre_y = rsp_y_ff;

endmodule
`default_nettype wire

// File: rtl/core/nsl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsl_checker
// Port-level checks of the nearest-seed labeler, bound to the top level.
// ----------------------------------------------------------------------------
module nsl_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [nsl_pkg::LABEL_BITS-1:0]     rsp_label,
   input wire logic [nsl_pkg::COORD_BITS-1:0]     rsp_centre_x,
   input wire logic [nsl_pkg::COORD_BITS-1:0]     rsp_centre_y
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_label)
         && $stable(rsp_centre_x) && $stable(rsp_centre_y))
      else $error("result word changed while stalled");

   // no result word right out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // one item at a time: the input closes once a word is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after accept");

   // a relax word carries no label
   a_relax_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_centre_x != '0 || rsp_centre_y != '0) |-> rsp_label == '0)
      else $error("relax word with nonzero label");

endmodule

bind nearest_seed_labeler_with_relaxation_unit nsl_checker u_nsl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_label    (rsp_label),
   .rsp_centre_x (rsp_centre_x),
   .rsp_centre_y (rsp_centre_y)
);
`default_nettype wire
